/* rtl/swpi_pkg.sv */
// Shared constants for the wall panel crossing core.
`timescale 1ns / 1ps
package swpi_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int COORD_BITS_MIN = 16;
	localparam int COORD_BITS_MAX = 48;
endpackage

/* rtl/segment_wall_panel_intersection_core.sv */
// Top level: pipelined test of a path segment against a vertical wall panel.
//
// One input item carries a panel edge A to B, its floor and ceiling, and a
// path segment start and end point, all signed Q16.8 coordinates. One result
// item, crosses_panel, comes out for every input item, in order.
// Both channels use valid and ready; an item moves when both are high.
// Throughput is one item per cycle while the pipeline is not held: every
// stage is a register stage and items enter back to back.
// The depth is set by two rounds of split multipliers, each two stages:
// the cross products of the differences, then the height products.
// When the receiver holds out_ready low while a result is waiting, the
// whole pipeline holds and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and in_ready is high.
// Degenerate inputs (parallel segment, zero-length edge or segment, zero
// height) give crosses_panel = 0.
`timescale 1ns / 1ps
module segment_wall_panel_intersection_core #(
	parameter int COORD_BITS = swpi_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] edge_start_x,
	input  logic signed [COORD_BITS-1:0] edge_start_y,
	input  logic signed [COORD_BITS-1:0] edge_end_x,
	input  logic signed [COORD_BITS-1:0] edge_end_y,
	input  logic signed [COORD_BITS-1:0] panel_floor,
	input  logic signed [COORD_BITS-1:0] panel_ceiling,
	input  logic signed [COORD_BITS-1:0] path_start_x,
	input  logic signed [COORD_BITS-1:0] path_start_y,
	input  logic signed [COORD_BITS-1:0] path_start_z,
	input  logic signed [COORD_BITS-1:0] path_end_x,
	input  logic signed [COORD_BITS-1:0] path_end_y,
	input  logic signed [COORD_BITS-1:0] path_end_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         crosses_panel
);
	import swpi_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int MW = 2 * DW;
	localparam int PW = MW + 1;
	localparam int NW = PW + 1;
	localparam int HW = DW + 1;
	localparam int QW = DW + NW;
	localparam int VW = QW + 2;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [DW-1:0] ex_s1, ey_s1, lx_s1, ly_s1, lz_s1, wx_s1, wy_s1;
	logic signed [DW-1:0] szfl_s1, h_s1;
	logic signed [DW-1:0] lz_s2, szfl_s2, h_s2;
	logic signed [DW-1:0] lz_s3, szfl_s3, h_s3;
	logic signed [DW-1:0] lz_s4, szfl_s4, h_s4;
	logic signed [MW-1:0] m_ly_ex, m_lx_ey, m_wy_ex, m_wx_ey, m_lx_wy, m_ly_wx;
	logic signed [PW-1:0] den_s4, num_s4, unum_s4;
	logic signed [NW-1:0] denx, numx, unumx;
	logic signed [HW-1:0] hx;
	logic signed [NW-1:0] d_s5, n_s5, u_s5;
	logic signed [HW-1:0] h_s5;
	logic signed [DW-1:0] lz_s5, szfl_s5;
	logic                 hneg_s5, dz_s5, hz_s5;
	logic                 ok_s6, hneg_s6, ok_s7, hneg_s7, ok_s8;
	logic signed [QW-1:0] q_sd, q_ln;
	logic signed [HW+NW-1:0] q_hd;
	logic signed [VW-1:0] vsum;
	logic signed [VW-1:0] v_val_s8, hd_s8;
	logic                 hit_s9;

	assign en       = !v_s9 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
			v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1   <= DW'(edge_end_x) - DW'(edge_start_x);
			ey_s1   <= DW'(edge_end_y) - DW'(edge_start_y);
			lx_s1   <= DW'(path_end_x) - DW'(path_start_x);
			ly_s1   <= DW'(path_end_y) - DW'(path_start_y);
			lz_s1   <= DW'(path_end_z) - DW'(path_start_z);
			wx_s1   <= DW'(edge_start_x) - DW'(path_start_x);
			wy_s1   <= DW'(edge_start_y) - DW'(path_start_y);
			szfl_s1 <= DW'(path_start_z) - DW'(panel_floor);
			h_s1    <= DW'(panel_ceiling) - DW'(panel_floor);
			lz_s2 <= lz_s1; szfl_s2 <= szfl_s1; h_s2 <= h_s1;
			lz_s3 <= lz_s2; szfl_s3 <= szfl_s2; h_s3 <= h_s2;
			lz_s4 <= lz_s3; szfl_s4 <= szfl_s3; h_s4 <= h_s3;
		end
	end

	swpi_mul #(.WA(DW), .WB(DW)) u_mul_ly_ex (
		.clk(clk), .en(en), .a(ly_s1), .b(ex_s1), .p(m_ly_ex));
	swpi_mul #(.WA(DW), .WB(DW)) u_mul_lx_ey (
		.clk(clk), .en(en), .a(lx_s1), .b(ey_s1), .p(m_lx_ey));
	swpi_mul #(.WA(DW), .WB(DW)) u_mul_wy_ex (
		.clk(clk), .en(en), .a(wy_s1), .b(ex_s1), .p(m_wy_ex));
	swpi_mul #(.WA(DW), .WB(DW)) u_mul_wx_ey (
		.clk(clk), .en(en), .a(wx_s1), .b(ey_s1), .p(m_wx_ey));
	swpi_mul #(.WA(DW), .WB(DW)) u_mul_lx_wy (
		.clk(clk), .en(en), .a(lx_s1), .b(wy_s1), .p(m_lx_wy));
	swpi_mul #(.WA(DW), .WB(DW)) u_mul_ly_wx (
		.clk(clk), .en(en), .a(ly_s1), .b(wx_s1), .p(m_ly_wx));

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4  <= PW'(m_ly_ex) - PW'(m_lx_ey);
			num_s4  <= PW'(m_wy_ex) - PW'(m_wx_ey);
			unum_s4 <= PW'(m_lx_wy) - PW'(m_ly_wx);
		end
	end

	assign denx  = NW'(den_s4);
	assign numx  = NW'(num_s4);
	assign unumx = NW'(unum_s4);
	assign hx    = HW'(h_s4);

	// normalize signs so the segment denominator and height are nonnegative
	always_ff @(posedge clk) begin
		if (en) begin
			d_s5    <= den_s4[PW-1] ? -denx : denx;
			n_s5    <= den_s4[PW-1] ? -numx : numx;
			u_s5    <= den_s4[PW-1] ? -unumx : unumx;
			h_s5    <= h_s4[DW-1] ? -hx : hx;
			hneg_s5 <= h_s4[DW-1];
			dz_s5   <= (den_s4 == '0);
			hz_s5   <= (h_s4 == '0);
			lz_s5   <= lz_s4;
			szfl_s5 <= szfl_s4;
		end
	end

	swpi_mul #(.WA(DW), .WB(NW)) u_mul_sd (
		.clk(clk), .en(en), .a(szfl_s5), .b(d_s5), .p(q_sd));
	swpi_mul #(.WA(DW), .WB(NW)) u_mul_ln (
		.clk(clk), .en(en), .a(lz_s5), .b(n_s5), .p(q_ln));
	swpi_mul #(.WA(HW), .WB(NW)) u_mul_hd (
		.clk(clk), .en(en), .a(h_s5), .b(d_s5), .p(q_hd));

	assign vsum = VW'(q_sd) + VW'(q_ln);

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s6    <= !dz_s5 && !hz_s5 && !n_s5[NW-1] && (n_s5 <= d_s5)
				&& !u_s5[NW-1] && (u_s5 <= d_s5);
			hneg_s6  <= hneg_s5;
			ok_s7    <= ok_s6;
			hneg_s7  <= hneg_s6;
			ok_s8    <= ok_s7;
			v_val_s8 <= hneg_s7 ? -vsum : vsum;
			hd_s8    <= VW'(q_hd);
			hit_s9   <= ok_s8 && !v_val_s8[VW-1] && (v_val_s8 <= hd_s8);
		end
	end

	assign out_valid     = v_s9;
	assign crosses_panel = hit_s9;
endmodule

/* rtl/swpi_mul.sv */
// Two-stage signed multiplier, operand b split into a low and a high half.
`timescale 1ns / 1ps
module swpi_mul #(
	parameter int WA = 25,
	parameter int WB = 25
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [WA-1:0]      a,
	input  logic signed [WB-1:0]      b,
	output logic signed [WA+WB-1:0]   p
);
	import swpi_pkg::*;

	localparam int LO = WB / 2;
	localparam int HI = WB - LO;

	logic signed [LO:0]         b_lo;
	logic signed [HI-1:0]       b_hi;
	logic signed [WA+LO:0]      pl_s1;
	logic signed [WA+HI-1:0]    ph_s1;
	logic signed [WA+WB-1:0]    plx;
	logic signed [WA+WB-1:0]    phx;
	logic signed [WA+WB-1:0]    p_s2;

	assign b_lo = $signed({1'b0, b[LO-1:0]});
	assign b_hi = $signed(b[WB-1:LO]);

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= a * b_lo;
			ph_s1 <= a * b_hi;
		end
	end

	assign plx = $signed({{(HI-1){pl_s1[WA+LO]}}, pl_s1});
	assign phx = $signed({ph_s1, {LO{1'b0}}});

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= phx + plx;
		end
	end

	assign p = p_s2;
endmodule
